// ===== hdl/hatl_pkg.sv =====
// Shared types, constants and helpers for the hourly average temperature limiter.
// Used by every module under hdl/; depends on nothing else.

package hatl_pkg;

    localparam int RING_DEPTH = 24;
    localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int COUNT_W    = $clog2(RING_DEPTH + 1);
    localparam int SUM_W      = 16 + SLOT_W;
    localparam int DIV_CYC    = (SUM_W + 1) / 2;
    localparam int DIV_W      = 2 * DIV_CYC;
    localparam int DCNT_W     = $clog2(DIV_CYC + 1);

    localparam int TEMP_W     = 16;
    localparam int TIME_W     = 32;
    localparam int OFFSET_W   = 15;
    localparam int HELD_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET     = 15'd500;
    localparam logic [TEMP_W-1:0]   NO_READING_RESET = 16'h8000;
    localparam logic [TIME_W-1:0]   INTERVAL_RESET   = 32'd3600000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_ABOVE = 2'd0,
        REG_OFFSET_BELOW = 2'd1,
        REG_NO_READING   = 2'd2,
        REG_INTERVAL     = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_START,
        ST_DIV,
        ST_BAND
    } state_t;

    typedef struct packed {
        logic capture;
        logic read_old;
        logic update;
        logic div_start;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } status_t;

    // Saturate an 18-bit signed band limit to the 16-bit signed range.
    function automatic logic signed [TEMP_W-1:0] sat16(input logic signed [17:0] v);
        logic signed [TEMP_W-1:0] r;
        begin
            if (v > 18'sd32767)
            begin
                r = 16'sh7FFF;
            end
            else if (v < -18'sd32768)
            begin
                r = 16'sh8000;
            end
            else
            begin
                r = v[TEMP_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

// ===== hdl/hourly_average_temperature_limiter.sv =====
// One transaction at a time: in_stall holds off a new input from acceptance until the
// result is loaded into the output register; in between, the iterative divider (two
// quotient bits per cycle over the running sum) forms the average.
// A finished result waits in the output register while the next input is taken.
// Reset (rst_n, async, active low) clears control state, history counters and
// restores configuration defaults; ring contents stay undefined until written.

module hourly_average_temperature_limiter
    import hatl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [TIME_W-1:0]         now_ms,
    input  logic signed [TEMP_W-1:0]  reading,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [TEMP_W-1:0]  limited_temp,
    output logic signed [TEMP_W-1:0]  average_temp,
    output logic                      sample_taken,
    output logic [HELD_W-1:0]         samples_held,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    cmd_t    cmd;
    status_t status;

    hatl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    hatl_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .now_ms       (now_ms),
        .reading      (reading),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .limited_temp (limited_temp),
        .average_temp (average_temp),
        .sample_taken (sample_taken),
        .samples_held (samples_held)
    );

endmodule

// ===== hdl/hatl_div.sv =====
// Iterative signed divider: running sum over sample count, truncated toward zero.
// Restoring division, two quotient bits per cycle. Depends on hatl_pkg.

module hatl_div
    import hatl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [SUM_W-1:0]   dividend,
    input  logic [COUNT_W-1:0]        divisor,
    output logic                      done,
    output logic signed [TEMP_W-1:0]  quotient
);

    logic [DIV_W-1:0]   q_reg, q_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] div_reg;
    logic               neg_reg;
    logic [DCNT_W-1:0]  cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [SUM_W-1:0]   mag;
    logic [COUNT_W:0]   r1, r2;
    logic               b1, b2;

    assign mag = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

    always_comb
    begin
        r1 = {rem_reg, q_reg[DIV_W-1]};
        b1 = (r1 >= {1'b0, div_reg});
        if (b1)
        begin
            r1 = r1 - {1'b0, div_reg};
        end
        r2 = {r1[COUNT_W-1:0], q_reg[DIV_W-2]};
        b2 = (r2 >= {1'b0, div_reg});
        if (b2)
        begin
            r2 = r2 - {1'b0, div_reg};
        end
    end

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = DIV_W'(mag);
            rem_next  = '0;
            cnt_next  = DCNT_W'(DIV_CYC);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DIV_W-3:0], b1, b2};
            rem_next = r2[COUNT_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            div_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~q_reg[TEMP_W-1:0] + 1'b1) : q_reg[TEMP_W-1:0];

endmodule

// ===== hdl/hatl_dp.sv =====
// Datapath: configuration registers, sample ring, running sum, band clamp, output register.
// Driven by hatl_ctrl commands; uses hatl_div and hatl_pkg.

module hatl_dp
    import hatl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic [TIME_W-1:0]         now_ms,
    input  logic signed [TEMP_W-1:0]  reading,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [TEMP_W-1:0]  limited_temp,
    output logic signed [TEMP_W-1:0]  average_temp,
    output logic                      sample_taken,
    output logic [HELD_W-1:0]         samples_held
);

    // Configuration
    logic [OFFSET_W-1:0]       above_reg;
    logic [OFFSET_W-1:0]       below_reg;
    logic signed [TEMP_W-1:0]  noread_reg;
    logic [TIME_W-1:0]         interval_reg;

    // Item and history state
    logic [TIME_W-1:0]         now_reg;
    logic signed [TEMP_W-1:0]  reading_reg;
    logic signed [TEMP_W-1:0]  old_reg;
    logic                      take_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [TIME_W-1:0]         last_time_reg;
    logic                      has_sampled_reg;
    logic signed [TEMP_W-1:0]  ring [RING_DEPTH];

    // Output register
    logic                      out_valid_reg;
    logic signed [TEMP_W-1:0]  limited_reg;
    logic signed [TEMP_W-1:0]  avg_out_reg;
    logic                      taken_out_reg;
    logic [HELD_W-1:0]         held_out_reg;

    logic                      full;
    logic [TIME_W-1:0]         elapsed;
    logic                      take_next;
    logic signed [TEMP_W-1:0]  quotient;
    logic                      div_done;
    logic signed [TEMP_W-1:0]  avg;
    logic signed [TEMP_W-1:0]  upper, lower, limited;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg    <= OFFSET_RESET;
            below_reg    <= OFFSET_RESET;
            noread_reg   <= NO_READING_RESET;
            interval_reg <= INTERVAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_OFFSET_ABOVE: above_reg    <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_BELOW: below_reg    <= cfg_data[OFFSET_W-1:0];
                REG_NO_READING:   noread_reg   <= cfg_data[TEMP_W-1:0];
                REG_INTERVAL:     interval_reg <= cfg_data[TIME_W-1:0];
                default:          ;
            endcase
        end
    end

    assign full      = (count_reg == COUNT_W'(RING_DEPTH));
    assign elapsed   = now_reg - last_time_reg;
    assign take_next = (reading_reg != noread_reg)
                       && (!has_sampled_reg || (elapsed > interval_reg));

    // Drop the oldest sample from the sum once the ring is full.
    assign sum_next = sum_reg - (full ? SUM_W'(old_reg) : '0) + SUM_W'(reading_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg     <= now_ms;
            reading_reg <= reading;
        end
        if (cmd.read_old)
        begin
            old_reg <= ring[slot_reg];
        end
        if (cmd.update && take_reg)
        begin
            ring[slot_reg] <= reading_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take_reg        <= 1'b0;
            slot_reg        <= '0;
            count_reg       <= '0;
            sum_reg         <= '0;
            last_time_reg   <= '0;
            has_sampled_reg <= 1'b0;
        end
        else
        begin
            if (cmd.read_old)
            begin
                take_reg <= take_next;
            end
            if (cmd.update && take_reg)
            begin
                sum_reg         <= sum_next;
                last_time_reg   <= now_reg;
                has_sampled_reg <= 1'b1;
                if (!full)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (slot_reg == SLOT_W'(RING_DEPTH - 1))
                begin
                    slot_reg <= '0;
                end
                else
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
        end
    end

    hatl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign avg   = (count_reg == '0) ? noread_reg : quotient;
    assign upper = sat16(18'(avg) + 18'(above_reg));
    assign lower = sat16(18'(avg) - 18'(below_reg));

    always_comb
    begin
        if (reading_reg > upper)
        begin
            limited = upper;
        end
        else if (reading_reg < lower)
        begin
            limited = lower;
        end
        else
        begin
            limited = reading_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            limited_reg   <= limited;
            avg_out_reg   <= avg;
            taken_out_reg <= take_reg;
            held_out_reg  <= HELD_W'(count_reg);
        end
    end

    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign limited_temp = limited_reg;
    assign average_temp = avg_out_reg;
    assign sample_taken = taken_out_reg;
    assign samples_held = held_out_reg;

endmodule

// ===== hdl/hatl_ctrl.sv =====
// Controller state machine: sequences capture, ring update, division and output load.
// Talks to hatl_dp through cmd_t / status_t from hatl_pkg.

module hatl_ctrl
    import hatl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_START;
            ST_START:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_BAND;
                end
            end
            ST_BAND:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall      = (state_reg != ST_IDLE);
        cmd.capture   = (state_reg == ST_IDLE) && in_valid;
        cmd.read_old  = (state_reg == ST_READ);
        cmd.update    = (state_reg == ST_UPDATE);
        cmd.div_start = (state_reg == ST_START);
        cmd.load_out  = (state_reg == ST_BAND) && status.out_free;
    end

endmodule

// ===== hdl/hatl_checker.sv =====
// Port-level checker for the hourly average temperature limiter, bound to the top level.
// Depends on hatl_pkg and hourly_average_temperature_limiter.

module hatl_checker
    import hatl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               sample_taken,
    input logic [HELD_W-1:0]  samples_held
);

    // A taken transaction keeps the input stalled while it is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepting a transaction");

    // The ring never reports more samples than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> samples_held <= HELD_W'(RING_DEPTH))
        else $error("samples_held exceeds ring depth");

    // A stored reading means the ring cannot be empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sample_taken |-> samples_held != '0)
        else $error("sample taken but ring reported empty");

    // A stalled result stays presented.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind hourly_average_temperature_limiter hatl_checker u_hatl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_taken (sample_taken),
    .samples_held (samples_held)
);
